FILE: sv/shs_pkg.sv
// ----------------------------------------------------------------------------
// shs_pkg
// Shared types and constants of the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package shs_pkg;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [31:0] data;
    logic [2:0]  n_bytes;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        digest_end;
  } out_item_t;

  typedef struct packed {
    logic             load;
    logic [7:0][31:0] words;
  } digest_load_t;

  localparam logic [2:0] FULL_WORD_BYTES = 3'd4;

  localparam logic [31:0] K_TABLE [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0][31:0] IV_WORDS = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

endpackage

`default_nettype wire

FILE: sv/shs_in_queue.sv
// ----------------------------------------------------------------------------
// shs_in_queue
// Input queue that takes message words and clamps their byte counts.
// ----------------------------------------------------------------------------
`default_nettype none

module shs_in_queue #(
  parameter int DEPTH = shs_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  output logic                  full,
  input  wire shs_pkg::in_item_t item,
  output logic                  q_valid,
  output shs_pkg::in_item_t     q_item,
  input  wire logic             q_pop
);
  import shs_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

  in_item_t      mem_r [DEPTH];
  logic [PW-1:0] wr_r, rd_r;
  logic [CW-1:0] cnt_r;
  in_item_t      clamped;
  logic          do_push, do_pop;

  assign full    = (cnt_r == DEPTH_C);
  assign q_valid = (cnt_r != '0);
  assign q_item  = mem_r[rd_r];
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;

  always_comb begin
    clamped = item;
    if (item.n_bytes > FULL_WORD_BYTES) begin
      clamped.n_bytes = FULL_WORD_BYTES;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= clamped;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= (wr_r == LAST_PTR) ? '0 : wr_r + 1'b1;
      end
      if (do_pop) begin
        rd_r <= (rd_r == LAST_PTR) ? '0 : rd_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/shs_core.sv
// ----------------------------------------------------------------------------
// shs_core
// Block assembly, padding and the 64-round compression sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module shs_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  input  wire shs_pkg::in_item_t q_item,
  output logic                   q_pop,
  input  wire logic              out_free,
  output shs_pkg::digest_load_t  dg
);
  import shs_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_COMP = 7'b0000010,
    S_FIN  = 7'b0000100,
    S_LEFT = 7'b0001000,
    S_PAD  = 7'b0010000,
    S_PAD2 = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  typedef logic [63:0][7:0] block_t;

  state_t           state_r, state_nxt, ret_r, ret_nxt;
  block_t           buf_r, buf_nxt;
  logic [7:0][31:0] chain_r, chain_nxt, work_r, work_nxt;
  logic [5:0]       pos_r, pos_nxt, round_r, round_nxt;
  logic [63:0]      bits_r, bits_nxt;
  logic [31:0]      left_data_r, left_data_nxt;
  logic [1:0]       left_n_r, left_n_nxt;
  logic             last_pend_r, last_pend_nxt;

  logic [6:0]  pos_sum, room, placed;
  logic [31:0] w0, w1, w9, w14, s0, s1, t1, t2, ch, mj, bs0, bs1;

  function automatic block_t put_bytes(block_t b, logic [5:0] pos, logic [31:0] d,
                                       logic [2:0] n);
    block_t     r;
    logic [6:0] p;
    r = b;
    for (int i = 0; i < 4; i++) begin
      p = {1'b0, pos} + 7'(i);
      if (3'(i) < n && !p[6]) begin
        r[p[5:0]] = d[31-8*i -: 8];
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] get_word(block_t b, int j);
    return {b[4*j], b[4*j+1], b[4*j+2], b[4*j+3]};
  endfunction

  function automatic logic [31:0] ror(logic [31:0] v, int s);
    return (v >> s) | (v << (32 - s));
  endfunction

  function automatic block_t put_length(block_t b, logic [63:0] len);
    block_t r;
    r = b;
    for (int i = 0; i < 8; i++) begin
      r[56+i] = len[63-8*i -: 8];
    end
    return r;
  endfunction

  assign w0  = get_word(buf_r, 0);
  assign w1  = get_word(buf_r, 1);
  assign w9  = get_word(buf_r, 9);
  assign w14 = get_word(buf_r, 14);
  assign s0  = ror(w1, 7) ^ ror(w1, 18) ^ (w1 >> 3);
  assign s1  = ror(w14, 17) ^ ror(w14, 19) ^ (w14 >> 10);
  assign bs1 = ror(work_r[4], 6) ^ ror(work_r[4], 11) ^ ror(work_r[4], 25);
  assign bs0 = ror(work_r[0], 2) ^ ror(work_r[0], 13) ^ ror(work_r[0], 22);
  assign ch  = (work_r[4] & work_r[5]) ^ (~work_r[4] & work_r[6]);
  assign mj  = (work_r[0] & work_r[1]) ^ (work_r[0] & work_r[2]) ^ (work_r[1] & work_r[2]);
  assign t1  = work_r[7] + bs1 + ch + K_TABLE[round_r] + w0;
  assign t2  = bs0 + mj;

  assign pos_sum = {1'b0, pos_r} + {4'd0, q_item.n_bytes};
  assign room    = 7'd64 - {1'b0, pos_r};
  assign placed  = ({4'd0, q_item.n_bytes} < room) ? {4'd0, q_item.n_bytes} : room;

  assign q_pop    = (state_r == S_IDLE) && q_valid;
  assign dg.load  = (state_r == S_DONE) && out_free;
  assign dg.words = chain_r;

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    buf_nxt       = buf_r;
    chain_nxt     = chain_r;
    work_nxt      = chain_r;
    pos_nxt       = pos_r;
    round_nxt     = '0;
    bits_nxt      = bits_r;
    left_data_nxt = left_data_r;
    left_n_nxt    = left_n_r;
    last_pend_nxt = last_pend_r;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          buf_nxt  = put_bytes(buf_r, pos_r, q_item.data, q_item.n_bytes);
          bits_nxt = bits_r + {58'd0, q_item.n_bytes, 3'd0};
          last_pend_nxt = q_item.last;
          if (pos_sum[6]) begin
            pos_nxt       = '0;
            left_n_nxt    = pos_sum[1:0];
            left_data_nxt = q_item.data << {placed[2:0], 3'd0};
            ret_nxt       = S_LEFT;
            state_nxt     = S_COMP;
          end else begin
            pos_nxt = pos_sum[5:0];
            if (q_item.last) begin
              state_nxt = S_PAD;
            end
          end
        end
      end
      S_COMP: begin
        work_nxt[7] = work_r[6];
        work_nxt[6] = work_r[5];
        work_nxt[5] = work_r[4];
        work_nxt[4] = work_r[3] + t1;
        work_nxt[3] = work_r[2];
        work_nxt[2] = work_r[1];
        work_nxt[1] = work_r[0];
        work_nxt[0] = t1 + t2;
        for (int j = 0; j < 60; j++) begin
          buf_nxt[j] = buf_r[j+4];
        end
        {buf_nxt[60], buf_nxt[61], buf_nxt[62], buf_nxt[63]} = s1 + w9 + s0 + w0;
        round_nxt = round_r + 1'b1;
        if (round_r == 6'd63) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        for (int j = 0; j < 8; j++) begin
          chain_nxt[j] = chain_r[j] + work_r[j];
        end
        state_nxt = ret_r;
      end
      S_LEFT: begin
        buf_nxt   = put_bytes(buf_r, 6'd0, left_data_r, {1'b0, left_n_r});
        pos_nxt   = {4'd0, left_n_r};
        state_nxt = last_pend_r ? S_PAD : S_IDLE;
      end
      S_PAD: begin
        for (int j = 0; j < 64; j++) begin
          if (6'(j) == pos_r) begin
            buf_nxt[j] = 8'h80;
          end else if (6'(j) > pos_r) begin
            buf_nxt[j] = 8'h00;
          end
        end
        if (pos_r <= 6'd55) begin
          buf_nxt = put_length(buf_nxt, bits_r);
          ret_nxt = S_DONE;
        end else begin
          ret_nxt = S_PAD2;
        end
        state_nxt = S_COMP;
      end
      S_PAD2: begin
        buf_nxt   = put_length('0, bits_r);
        ret_nxt   = S_DONE;
        state_nxt = S_COMP;
      end
      S_DONE: begin
        if (out_free) begin
          chain_nxt     = IV_WORDS;
          pos_nxt       = '0;
          bits_nxt      = '0;
          last_pend_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    buf_r       <= buf_nxt;
    work_r      <= work_nxt;
    left_data_r <= left_data_nxt;
    left_n_r    <= left_n_nxt;
    ret_r       <= ret_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      chain_r     <= IV_WORDS;
      pos_r       <= '0;
      round_r     <= '0;
      bits_r      <= '0;
      last_pend_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chain_r     <= chain_nxt;
      pos_r       <= pos_nxt;
      round_r     <= round_nxt;
      bits_r      <= bits_nxt;
      last_pend_r <= last_pend_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/shs_digest_out.sv
// ----------------------------------------------------------------------------
// shs_digest_out
// Digest buffer that hands out the eight hash words one transfer at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module shs_digest_out (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire shs_pkg::digest_load_t dg,
  output logic                      out_free,
  output logic                      empty,
  input  wire logic                 pop,
  output shs_pkg::out_item_t        item
);
  import shs_pkg::*;

  logic [7:0][31:0] words_r;
  logic [2:0]       idx_r;
  logic             valid_r;

  assign out_free         = !valid_r;
  assign empty            = !valid_r;
  assign item.digest_word = words_r[idx_r];
  assign item.word_index  = idx_r;
  assign item.digest_end  = (idx_r == 3'd7);

  always_ff @(posedge clk) begin
    if (dg.load && !valid_r) begin
      words_r <= dg.words;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (dg.load && !valid_r) begin
      valid_r <= 1'b1;
      idx_r   <= '0;
    end else if (pop && valid_r) begin
      idx_r <= idx_r + 1'b1;
      if (idx_r == 3'd7) begin
        valid_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/sha256_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// Streaming SHA-256 engine with queue-style input and digest channels.
// ----------------------------------------------------------------------------
// Message words enter through in_push/in_full, first byte in bits 31..24,
// with 0 to 4 valid bytes; a word with last set closes the message.
// Words wait in a short input queue while the engine works on earlier ones.
// Words merge into the block one at a time while the engine is idle; a full
// 64-byte block then runs the 64 rounds, the chain update and the placing of
// leftover bytes, and the queue is not read until that is done.
// After the last word the engine pads and compresses one or two more blocks,
// hands the digest to its buffer and restarts from the initial hash; the
// buffer offers the eight digest words, index 0 first, on out_empty/out_pop.
// If the receiver stalls, the digest waits in its buffer; the engine keeps
// hashing the next message and holds only when that one is also finished.
// Reset empties both channels and loads the initial hash values.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_stream_hasher #(
  parameter int QUEUE_DEPTH = shs_pkg::QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire shs_pkg::in_item_t  in_item,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output shs_pkg::out_item_t      out_item
);
  import shs_pkg::*;

  logic         q_valid, q_pop, out_free;
  in_item_t     q_item;
  digest_load_t dg;

  shs_in_queue #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push),
    .full    (in_full),
    .item    (in_item),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  shs_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .out_free (out_free),
    .dg       (dg)
  );

  shs_digest_out u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .dg       (dg),
    .out_free (out_free),
    .empty    (out_empty),
    .pop      (out_pop),
    .item     (out_item)
  );

endmodule

`default_nettype wire

FILE: sv/shs_checker.sv
// ----------------------------------------------------------------------------
// shs_checker
// Port-level checks of the digest channel of the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
`default_nettype none

module shs_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_empty,
  input wire logic               out_pop,
  input wire shs_pkg::out_item_t out_item
);
  import shs_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_item)))
    else $error("Digest word changed while stalled.");

  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_item.digest_end == (out_item.word_index == 3'd7)))
    else $error("Digest end flag does not match the word index.");

  a_next: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_pop && !out_item.digest_end) |=>
      (!out_empty && out_item.word_index == $past(out_item.word_index) + 3'd1))
    else $error("Digest words were not delivered in order.");

  a_first: assert property (@(posedge clk) disable iff (!rst_n)
    (out_empty && $past(out_empty)) |=> (out_empty || out_item.word_index == 3'd0))
    else $error("Digest did not start with word zero.");

  a_reset: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("Digest channel not empty after reset.");

endmodule

bind sha256_stream_hasher shs_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_item  (out_item)
);

`default_nettype wire
